// ===== hw/rtl/i2crm_pkg.sv =====
package i2crm_pkg;

	// bus event codes; six and seven are unused
	typedef enum logic [2:0] {
		FN_WR_START = 3'd0,
		FN_RD_START = 3'd1,
		FN_BYTE     = 3'd2,
		FN_TX_REQ   = 3'd3,
		FN_STOP     = 3'd4,
		FN_LOCAL_RD = 3'd5
	} func_t;

	// transfer mode of the bus side
	typedef enum logic [2:0] {
		MD_WAIT     = 3'd0,
		MD_GET_PTR  = 3'd1,
		MD_GET_DATA = 3'd2,
		MD_SEND     = 3'd3,
		MD_DROP     = 3'd4
	} mode_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_LOOK = 1'b1
	} ctrl_state_t;

	// commands from controller to datapath
	typedef struct packed {
		logic take;    // word accepted this cycle
		logic finish;  // load result register this cycle
	} ctrl_cmd_t;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned FUNC_W = 3;

endpackage

// ===== hw/rtl/i2crm_req_if.sv =====
interface i2crm_req_if import i2crm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FUNC_W-1:0]   func;
	logic [BYTE_W-1:0]   byte_in;
	logic [BYTE_W-1:0]   local_index;

	modport source (output valid, output func, output byte_in, output local_index,
		input ready);
	modport sink (input valid, input func, input byte_in, input local_index,
		output ready);
endinterface

// ===== hw/rtl/i2crm_rsp_if.sv =====
interface i2crm_rsp_if import i2crm_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [BYTE_W-1:0]   data_out;
	logic                byte_stored;
	logic                dropping;

	modport source (output valid, output data_out, output byte_stored, output dropping,
		input ready);
	modport sink (input valid, input data_out, input byte_stored, input dropping,
		output ready);
endinterface

// ===== hw/rtl/i2crm_ram.sv =====
module i2crm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== hw/rtl/i2crm_ctrl.sv =====
module i2crm_ctrl import i2crm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  logic      rsp_ready,
	output logic      rsp_valid,
	output ctrl_cmd_t cmd
);
	ctrl_state_t state_q, state_d;
	logic        rsp_valid_q, rsp_valid_d;

	// outputs
	always_comb begin
		req_ready  = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready);
		cmd.take   = req_ready && req_valid;
		cmd.finish = (state_q == ST_LOOK);
	end

	// next state
	always_comb begin
		unique case (state_q)
			ST_IDLE: begin
				state_d = cmd.take ? ST_LOOK : ST_IDLE;
			end
			ST_LOOK: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_valid_d = rsp_valid_q;
		if (cmd.finish) begin
			rsp_valid_d = 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
endmodule

// ===== hw/rtl/i2crm_datapath.sv =====
module i2crm_datapath import i2crm_pkg::*; #(
	parameter int unsigned MAP_BYTES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	input  logic [FUNC_W-1:0]  func,
	input  logic [BYTE_W-1:0]  byte_in,
	input  logic [BYTE_W-1:0]  local_index,
	output logic [BYTE_W-1:0]  data_out,
	output logic               byte_stored,
	output logic               dropping
);
	localparam int unsigned AW = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
	localparam logic [BYTE_W-1:0] MAP_LIM = BYTE_W'(MAP_BYTES);

	mode_t              mode_q, mode_d;
	logic [BYTE_W-1:0]  wptr_q, wptr_d;
	logic [BYTE_W-1:0]  rdidx_q, rdidx_d;
	logic [BYTE_W-1:0]  wptr_inc;
	logic [MAP_BYTES-1:0] written_q;

	logic               do_write, do_read, hit;
	logic [BYTE_W-1:0]  raddr;
	logic               hit_s1, stored_s1, drop_s1;
	logic [BYTE_W-1:0]  ram_rdata;
	logic [BYTE_W-1:0]  data_out_q;
	logic               byte_stored_q, dropping_q;

	assign wptr_inc = wptr_q + 8'd1;

	// event decode
	always_comb begin
		mode_d   = mode_q;
		wptr_d   = wptr_q;
		rdidx_d  = rdidx_q;
		do_write = 1'b0;
		do_read  = 1'b0;
		raddr    = local_index;
		unique case (func_t'(func))
			FN_WR_START: begin
				mode_d = MD_GET_PTR;
			end
			FN_RD_START: begin
				mode_d  = MD_SEND;
				rdidx_d = '0;
			end
			FN_BYTE: begin
				if (mode_q == MD_GET_PTR) begin
					wptr_d = byte_in;
					mode_d = (byte_in >= MAP_LIM) ? MD_DROP : MD_GET_DATA;
				end else if (mode_q == MD_GET_DATA) begin
					do_write = (wptr_q < MAP_LIM);
					wptr_d   = wptr_inc;
					mode_d   = (wptr_inc >= MAP_LIM) ? MD_DROP : MD_GET_DATA;
				end
			end
			FN_TX_REQ: begin
				if (mode_q == MD_SEND) begin
					do_read = 1'b1;
					raddr   = rdidx_q;
					if (rdidx_q < MAP_LIM) begin
						rdidx_d = rdidx_q + 8'd1;
					end
				end
			end
			FN_STOP: begin
				mode_d = MD_DROP;
			end
			FN_LOCAL_RD: begin
				do_read = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// never-written entries read as zero
	assign hit = do_read && (raddr < MAP_LIM) && written_q[raddr[AW-1:0]];

	i2crm_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (MAP_BYTES)
	) u_map (
		.clk   (clk),
		.we    (cmd.take && do_write),
		.waddr (wptr_q[AW-1:0]),
		.wdata (byte_in),
		.re    (cmd.take && do_read),
		.raddr (raddr[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MD_WAIT;
			wptr_q    <= '0;
			rdidx_q   <= '0;
			written_q <= '0;
		end else if (cmd.take) begin
			mode_q  <= mode_d;
			wptr_q  <= wptr_d;
			rdidx_q <= rdidx_d;
			if (do_write) begin
				written_q[wptr_q[AW-1:0]] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			hit_s1    <= hit;
			stored_s1 <= do_write;
			drop_s1   <= (mode_d == MD_DROP);
		end
		if (cmd.finish) begin
			data_out_q    <= hit_s1 ? ram_rdata : '0;
			byte_stored_q <= stored_s1;
			dropping_q    <= drop_s1;
		end
	end

	assign data_out    = data_out_q;
	assign byte_stored = byte_stored_q;
	assign dropping    = dropping_q;
endmodule

// ===== hw/rtl/i2c_target_register_map_unit.sv =====
// result path: the request word is accepted, the map ram read and the stage flags are registered,
//   then the controller's look state loads the result register and raises the result valid
// requests are not taken back to back, set by the two-state controller loop (accept, then load result)
// a new request is taken while the previous result is being handed off
// reset: arst_n asynchronous, active low; mode to waiting, pointers to zero,
//   all map bytes read as zero until written
module i2c_target_register_map_unit import i2crm_pkg::*; #(
	parameter int unsigned MAP_BYTES = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	i2crm_req_if.sink   req,
	i2crm_rsp_if.source rsp
);
	ctrl_cmd_t cmd;

	// controller: handshake and sequencing only
	i2crm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_ready (rsp.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	// datapath: mode, pointers, map storage and result register
	i2crm_datapath #(
		.MAP_BYTES (MAP_BYTES)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.func        (req.func),
		.byte_in     (req.byte_in),
		.local_index (req.local_index),
		.data_out    (rsp.data_out),
		.byte_stored (rsp.byte_stored),
		.dropping    (rsp.dropping)
	);
endmodule

// ===== hw/rtl/i2crm_checker.sv =====
module i2crm_checker import i2crm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_ready,
	input logic              rsp_valid,
	input logic              rsp_ready,
	input logic [BYTE_W-1:0] rsp_data_out,
	input logic              rsp_byte_stored
);
	logic req_acc;
	assign req_acc = req_valid && req_ready;

	// result word held until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped before taken");

	// no request taken while a result would be left stuck
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> !rsp_valid || rsp_ready)
		else $error("request accepted with result register full");

	// one request in flight at a time
	a_one_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> !req_ready)
		else $error("second request accepted while busy");

	// every accepted request is followed by a valid result word
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |-> ##2 rsp_valid)
		else $error("result word missing after request");

	// a stored byte never carries transmit data
	a_stored_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_byte_stored |-> rsp_data_out == '0)
		else $error("stored byte with nonzero data");
endmodule

bind i2c_target_register_map_unit i2crm_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_data_out    (rsp.data_out),
	.rsp_byte_stored (rsp.byte_stored)
);
